>>> sv/hmf_pkg.sv
// Shared constants and types of the 3x3 harmonic mean filter.
package hmf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int FRAC_BITS  = 16;

   localparam int PIX_W      = 8;
   localparam int WIDTH_W    = 11;                  // image_width register
   localparam int HEIGHT_W   = 13;                  // image_height register
   localparam int COL_W      = $clog2(MAX_WIDTH);   // column counter / line store index
   localparam int ROW_W      = $clog2(MAX_HEIGHT);  // row counter
   localparam int CNT_W      = COL_W + 1;           // column arithmetic with headroom
   localparam int RCNT_W     = ROW_W + 1;           // row arithmetic with headroom
   localparam int MIN_DIM    = 3;
   localparam int WIN_SPAN   = 3;

   localparam int RECIP_W    = FRAC_BITS + 1;
   localparam int SUM_W      = FRAC_BITS + 5;
   localparam int QUO_W      = PIX_W + 1;
   localparam int DIV_W      = SUM_W + PIX_W;

   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = QPTR_W + 1;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef logic [WIN_SPAN-1:0][WIN_SPAN-1:0][PIX_W-1:0] hmf_window_type;

   typedef struct packed {
      hmf_window_type window;
      logic           last;
   } hmf_item_type;

   typedef struct packed {
      logic has_item;
      logic has_room;
   } hmf_qstat_type;

   typedef struct packed {
      logic [CNT_W-1:0]  width;
      logic [RCNT_W-1:0] height;
   } hmf_geom_type;

endpackage

>>> sv/hmf_intf.sv
// Handshake channel interfaces of the harmonic mean filter.
interface hmf_req_if;
   import hmf_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic             frame_start;
   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface hmf_rsp_if;
   import hmf_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] filtered;
   logic             last_of_frame;
   modport source (output valid, output filtered, output last_of_frame, input ready);
   modport sink   (input valid, input filtered, input last_of_frame, output ready);
endinterface

>>> sv/hmf_front.sv
// Front end: position counters, line stores and the 3x3 window.
module hmf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  hmf_pkg::hmf_geom_type geom,
   hmf_req_if.sink              req_chan,
   input  hmf_pkg::hmf_qstat_type qstat,
   output logic                 push,
   output hmf_pkg::hmf_item_type push_item
);
   import hmf_pkg::*;

   logic [PIX_W-1:0] line_a_mem [MAX_WIDTH];
   logic [PIX_W-1:0] line_b_mem [MAX_WIDTH];

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              v1_ff;
   logic [COL_W-1:0]  c1_ff;
   logic              emit1_ff, last1_ff;
   logic [PIX_W-1:0]  pix1_ff, rd_a_ff, rd_b_ff, fwd_data_ff;
   logic              fwd_ff;
   hmf_window_type    win_ff, win_in;

   logic              accept;
   logic [CNT_W-1:0]  col_base, col_cur, col_nxt;
   logic [RCNT_W-1:0] row_base, row_tmp, row_cur, row_nxt;
   logic              emit_cur, last_cur;
   logic [PIX_W-1:0]  up1, up2;

   assign req_chan.ready = qstat.has_room;
   assign accept = req_chan.valid & qstat.has_room;

   always_comb begin
      col_base = req_chan.frame_start ? '0 : CNT_W'(col_ff);
      row_base = req_chan.frame_start ? '0 : RCNT_W'(row_ff);
      // wrap a stale position left by a shrunk geometry
      if (col_base >= geom.width) begin
         col_cur = '0;
         row_tmp = row_base + RCNT_W'(1);
      end else begin
         col_cur = col_base;
         row_tmp = row_base;
      end
      row_cur = (row_tmp >= geom.height) ? '0 : row_tmp;
      emit_cur = (row_cur >= RCNT_W'(WIN_SPAN - 1)) && (col_cur >= CNT_W'(WIN_SPAN - 1));
      last_cur = (row_cur == geom.height - RCNT_W'(1)) && (col_cur == geom.width - CNT_W'(1));
      col_nxt = col_cur + CNT_W'(1);
      row_nxt = row_cur;
      if (col_nxt >= geom.width) begin
         col_nxt = '0;
         row_nxt = row_cur + RCNT_W'(1);
         if (row_nxt >= geom.height) begin
            row_nxt = '0;
         end
      end
      col_in = accept ? col_nxt[COL_W-1:0] : col_ff;
      row_in = accept ? row_nxt[ROW_W-1:0] : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         v1_ff  <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         v1_ff  <= accept;
         // the older beat's row-two-above write lands on this edge: forward it
         fwd_ff <= accept && v1_ff && (c1_ff == col_cur[COL_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c1_ff       <= col_cur[COL_W-1:0];
         emit1_ff    <= emit_cur;
         last1_ff    <= last_cur;
         pix1_ff     <= req_chan.pixel;
         fwd_data_ff <= rd_a_ff;
      end
   end

   // line store a: read the row above, write the current pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_a_ff <= line_a_mem[col_cur[COL_W-1:0]];
         line_a_mem[col_cur[COL_W-1:0]] <= req_chan.pixel;
      end
   end

   // line store b: read at acceptance, write the aged row in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_b_ff <= line_b_mem[col_cur[COL_W-1:0]];
      end
      if (v1_ff) begin
         line_b_mem[c1_ff] <= rd_a_ff;
      end
   end

   assign up1 = rd_a_ff;
   assign up2 = fwd_ff ? fwd_data_ff : rd_b_ff;

   always_comb begin
      win_in = win_ff;
      if (v1_ff) begin
         for (int r = 0; r < WIN_SPAN; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = up2;
         win_in[1][2] = up1;
         win_in[2][2] = pix1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   assign push             = v1_ff & emit1_ff;
   assign push_item.window = win_in;
   assign push_item.last   = last1_ff;

   a_fwd_follows_stage: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> $past(v1_ff))
      else $error("forwarding without an older beat in flight");

endmodule

>>> sv/hmf_queue.sv
// Short queue of full windows between the front end and the arithmetic back end.
module hmf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hmf_pkg::hmf_item_type  push_item,
   input  logic                   pop,
   output hmf_pkg::hmf_item_type  head,
   output hmf_pkg::hmf_qstat_type qstat
);
   import hmf_pkg::*;

   hmf_item_type       slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head           = slot_ff[rd_ptr_ff];
   assign qstat.has_item = (count_ff != '0);
   // keep room for the beat already between acceptance and the queue
   assign qstat.has_room = (count_ff <= QCNT_W'(QDEPTH - 2));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QCNT_W'(QDEPTH)) || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");

endmodule

>>> sv/hmf_back.sv
// Back end: reciprocal sum, shift-subtract division and the result register.
module hmf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  hmf_pkg::hmf_item_type  head,
   input  hmf_pkg::hmf_qstat_type qstat,
   output logic                   pop,
   hmf_rsp_if.source              rsp_chan
);
   import hmf_pkg::*;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_SUM  = 2'd1;
   localparam logic [1:0] B_DIV  = 2'd2;
   localparam logic [1:0] B_DONE = 2'd3;
   localparam int         NUM_LEVELS = 1 << PIX_W;
   localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(WIN_SPAN * WIN_SPAN) << FRAC_BITS;

   logic [RECIP_W-1:0] recip_tab [NUM_LEVELS];

   assign recip_tab[0] = '0;
   for (genvar g = 1; g < NUM_LEVELS; g++) begin : g_recip
      localparam longint RV = ((64'd1 << FRAC_BITS) + (g >> 1)) / g;
      assign recip_tab[g] = RECIP_W'(RV);
   end

   logic [1:0]        state_ff, state_in;
   hmf_window_type    win_ff;
   logic              last_ff, zero_ff;
   logic [3:0]        cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [DIV_W-1:0]  rem_ff, rem_in, dsr_ff, dsr_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  filt_ff;
   logic              rlast_ff;
   logic              any_zero, load_out;
   logic [WIN_SPAN-1:0][PIX_W-1:0] row_sel;

   always_comb begin
      any_zero = 1'b0;
      for (int r = 0; r < WIN_SPAN; r++) begin
         for (int c = 0; c < WIN_SPAN; c++) begin
            any_zero = any_zero | (head.window[r][c] == '0);
         end
      end
   end

   assign row_sel = win_ff[cnt_ff[1:0]];
   assign pop      = (state_ff == B_IDLE) && qstat.has_item;
   assign load_out = (state_ff == B_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop) begin
               state_in = B_SUM;
               cnt_in   = '0;
               sum_in   = '0;
            end
         end
         B_SUM: begin
            // add one window row of reciprocals per cycle
            sum_in = sum_ff + SUM_W'(recip_tab[row_sel[0]]) + SUM_W'(recip_tab[row_sel[1]])
                            + SUM_W'(recip_tab[row_sel[2]]);
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(WIN_SPAN - 1)) begin
               state_in = B_DIV;
               cnt_in   = 4'(QUO_W - 1);
               rem_in   = DIVIDEND;
               dsr_in   = {sum_in, {PIX_W{1'b0}}};
               quo_in   = '0;
            end
         end
         B_DIV: begin
            if (rem_ff >= dsr_ff) begin
               rem_in = rem_ff - dsr_ff;
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            dsr_in = dsr_ff >> 1;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (load_out) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      sum_ff <= sum_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      if (pop) begin
         win_ff  <= head.window;
         last_ff <= head.last;
         zero_ff <= any_zero;
      end
      if (load_out) begin
         // a zero pixel forces 0; a ninth quotient bit means saturate
         filt_ff  <= zero_ff ? '0 : (quo_ff[QUO_W-1] ? '1 : quo_ff[PIX_W-1:0]);
         rlast_ff <= last_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.filtered      = filt_ff;
   assign rsp_chan.last_of_frame = rlast_ff;

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_DONE))
      else $error("result shown without a finished division");

   // a window with zero pixels has a meaningless divisor; its quotient is dropped
   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == B_DIV) && !zero_ff) |-> ({1'b0, rem_ff} < {dsr_ff, 1'b0}))
      else $error("partial remainder outgrew the divisor");

endmodule

>>> sv/harmonic_mean_filter_3x3_core.sv
// Top level of the 3x3 harmonic mean filter: register port and block wiring.
//
// Pixels enter on req_chan in raster order, one beat per pixel; frame_start
// marks row 0, column 0. For each interior pixel (row and column >= 2) one
// beat leaves on rsp_chan with the harmonic mean of its 3x3 neighbourhood;
// last_of_frame flags the result at the last row and column of the frame.
// Border pixels give no result.
// Border pixels are taken at one per cycle while the queue has room. Each
// interior result occupies the back end from the take of its window through
// summing reciprocals a row at a time, nine steps of the shift-subtract
// divider and the load of the result register; a four-entry window queue
// lets the front run ahead of it.
// image_width and image_height must be written through the APB port while idle;
// the block does not enforce it. Reset sets them to 640 and 480 and clears
// counters, window and queue. Line stores are not cleared. When rsp_chan stalls,
// the result register holds, the back end waits, the queue fills and req_chan ready drops.
module harmonic_mean_filter_3x3_core (
   input  logic                           clock,
   input  logic                           reset,
   hmf_req_if.sink                        req_chan,
   hmf_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hmf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hmf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hmf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import hmf_pkg::*;

   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic                wr_en;
   hmf_geom_type        geom;
   hmf_qstat_type       qstat;
   hmf_item_type        push_item, head;
   logic                push, pop;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_IMAGE_WIDTH:  width_in  = pwdata[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[HEIGHT_W-1:0];
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_W'(640);
         height_ff <= HEIGHT_W'(480);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:          prdata = '0;
      endcase
   end

   // clamp the geometry to the supported range
   always_comb begin
      if (int'(width_ff) < MIN_DIM) begin
         geom.width = CNT_W'(MIN_DIM);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         geom.width = CNT_W'(MAX_WIDTH);
      end else begin
         geom.width = CNT_W'(width_ff);
      end
      if (int'(height_ff) < MIN_DIM) begin
         geom.height = RCNT_W'(MIN_DIM);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         geom.height = RCNT_W'(MAX_HEIGHT);
      end else begin
         geom.height = RCNT_W'(height_ff);
      end
   end

   hmf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom),
      .req_chan  (req_chan),
      .qstat     (qstat),
      .push      (push),
      .push_item (push_item)
   );

   hmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   hmf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
